// ===== src/sswq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted sleep/wake queue package
// Shared types, result kinds and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package sswq_pkg;

    localparam int SLOTS_DEF   = 16;  // default store depth
    localparam int MAX_RESULTS = 16;  // most threads woken by one tick
    localparam int WOKE_W      = $clog2(MAX_RESULTS + 1);
    localparam int TICK_W      = 63;
    localparam int WAKE_W      = 64;
    localparam int THR_W       = 8;
    localparam int PRI_W       = 6;
    localparam int DUR_W       = 32;
    localparam int IN_DATA_W   = 56;  // 52 bits of fields padded to bytes
    localparam int OUT_DATA_W  = 72;

    // Result kinds, as they appear on the output tuser.
    typedef enum logic [2:0] {
        KIND_ACCEPTED = 3'd0,
        KIND_IGNORED  = 3'd1,
        KIND_FULL     = 3'd2,
        KIND_WOKEN    = 3'd3,
        KIND_NONE     = 3'd4
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_in;   // capture the accepted input beat
        logic  compare;   // register the per-slot insert flags
        logic  insert;    // shift the store and write the new entry
        logic  tick_inc;  // advance the tick counter
        logic  pop;       // drop the head entry
        logic  emit;      // load the output register
        t_kind kind;
        logic  last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_tick;
        logic dur_bad;
        logic full;
        logic head_due;
        logic second_due;
        logic out_free;
    } t_status;

endpackage

// ===== src/sswq_dp.sv =====
// ----------------------------------------------------------------------------
// Sorted sleep/wake queue datapath
// Tick counter, sorted entry store with shift insert/pop, and output register.
// ----------------------------------------------------------------------------
module sswq_dp #(
    parameter int SLOTS = sswq_pkg::SLOTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sswq_pkg::t_cmd             i_cmd,
    output sswq_pkg::t_status          o_status,
    input  logic                       i_op,
    input  logic [sswq_pkg::THR_W-1:0] i_thr,
    input  logic [sswq_pkg::PRI_W-1:0] i_pri,
    input  logic [sswq_pkg::DUR_W-1:0] i_dur,
    input  logic [sswq_pkg::PRI_W-1:0] i_run,
    input  logic                       i_m_tready,
    output logic                       o_m_tvalid,
    output logic [2:0]                 o_kind,
    output logic [sswq_pkg::THR_W-1:0] o_woken,
    output logic                       o_yield,
    output logic [sswq_pkg::TICK_W-1:0] o_tick,
    output logic                       o_last
);

    localparam int CW = $clog2(SLOTS + 1);

    // Captured input beat.
    logic                        r_op;
    logic [sswq_pkg::THR_W-1:0]  r_thr_in;
    logic [sswq_pkg::PRI_W-1:0]  r_pri_in;
    logic [sswq_pkg::DUR_W-1:0]  r_dur;
    logic [sswq_pkg::PRI_W-1:0]  r_run;
    logic [sswq_pkg::WAKE_W-1:0] r_wake_new;

    logic [sswq_pkg::TICK_W-1:0] r_tick;
    logic [CW-1:0]               r_count;

    // Sorted store; slot 0 is the head.
    logic [sswq_pkg::WAKE_W-1:0] r_wake [SLOTS];
    logic [sswq_pkg::THR_W-1:0]  r_thr  [SLOTS];
    logic [sswq_pkg::PRI_W-1:0]  r_pri  [SLOTS];
    logic [SLOTS-1:0]            r_before;

    logic                        r_out_valid;
    logic [2:0]                  r_out_kind;
    logic [sswq_pkg::THR_W-1:0]  r_out_thr;
    logic                        r_out_yld;
    logic [sswq_pkg::TICK_W-1:0] r_out_tick;
    logic                        r_out_last;

    logic [sswq_pkg::WAKE_W-1:0] tick_ext;
    logic                        out_free;
    logic                        second_due;

    assign tick_ext = {1'b0, r_tick};
    assign out_free = !r_out_valid || i_m_tready;

    generate
        if (SLOTS > 1) begin : g_second
            assign second_due = (r_count > CW'(1)) && (r_wake[1] <= tick_ext);
        end else begin : g_no_second
            assign second_due = 1'b0;
        end
    endgenerate

    always_comb begin
        o_status.op_tick    = r_op;
        o_status.dur_bad    = (r_dur == '0) || r_dur[sswq_pkg::DUR_W-1];
        o_status.full       = (r_count == CW'(SLOTS));
        o_status.head_due   = (r_count != '0) && (r_wake[0] <= tick_ext);
        o_status.second_due = second_due;
        o_status.out_free   = out_free;
    end

    // Input capture. The wake tick is formed here so the compare step
    // sees a registered operand.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op       <= i_op;
            r_thr_in   <= i_thr;
            r_pri_in   <= i_pri;
            r_dur      <= i_dur;
            r_run      <= i_run;
            r_wake_new <= tick_ext + {{(sswq_pkg::WAKE_W-sswq_pkg::DUR_W){1'b0}}, i_dur};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.tick_inc) begin
                r_tick <= r_tick + 1'b1;
            end
            if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Per-slot logic: every slot compares against the new entry; on insert the
    // slots from the insertion point on move one place back, on pop one place forward.
    generate
        for (genvar i = 0; i < SLOTS; i++) begin : g_slot
            localparam logic [CW-1:0] IDX = CW'(i);
            logic take_new;

            if (i == 0) begin : g_first
                assign take_new = 1'b1;
            end else begin : g_rest
                assign take_new = !r_before[i-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.compare) begin
                    r_before[i] <= (IDX >= r_count) || (r_wake_new < r_wake[i]) ||
                                   ((r_wake_new == r_wake[i]) && (r_pri_in > r_pri[i]));
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && r_before[i]) begin
                    if (take_new) begin
                        r_wake[i] <= r_wake_new;
                        r_thr[i]  <= r_thr_in;
                        r_pri[i]  <= r_pri_in;
                    end else if (i > 0) begin
                        r_wake[i] <= r_wake[(i > 0) ? i-1 : 0];
                        r_thr[i]  <= r_thr[(i > 0) ? i-1 : 0];
                        r_pri[i]  <= r_pri[(i > 0) ? i-1 : 0];
                    end
                end else if (i_cmd.pop && (i < SLOTS - 1)) begin
                    r_wake[i] <= r_wake[(i < SLOTS - 1) ? i+1 : i];
                    r_thr[i]  <= r_thr[(i < SLOTS - 1) ? i+1 : i];
                    r_pri[i]  <= r_pri[(i < SLOTS - 1) ? i+1 : i];
                end
            end
        end
    endgenerate

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= i_cmd.kind;
            r_out_tick <= r_tick;
            r_out_last <= i_cmd.last;
            if (i_cmd.kind == sswq_pkg::KIND_WOKEN) begin
                r_out_thr <= r_thr[0];
                r_out_yld <= (r_pri[0] > r_run);
            end else begin
                r_out_thr <= '0;
                r_out_yld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_woken    = r_out_thr;
    assign o_yield    = r_out_yld;
    assign o_tick     = r_out_tick;
    assign o_last     = r_out_last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SLOTS))
        else $error("entry count exceeds store depth");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_count < CW'(SLOTS)))
        else $error("insert into a full store");

    a_pop_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0) && (r_wake[0] <= tick_ext))
        else $error("pop of an entry that is not due");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("output register overwritten before it was taken");

endmodule

// ===== src/sswq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Sorted sleep/wake queue controller
// Sequences decode, sorted insert and the wake loop of one item at a time.
// ----------------------------------------------------------------------------
module sswq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  sswq_pkg::t_status i_status,
    output sswq_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INSERT,
        S_REPORT,
        S_WAKE
    } t_state;

    t_state                      r_state, n_state;
    logic [sswq_pkg::WOKE_W-1:0] r_nwoke, n_nwoke;
    sswq_pkg::t_kind             r_report, n_report;

    always_comb begin
        n_state  = r_state;
        n_nwoke  = r_nwoke;
        n_report = r_report;
        o_cmd    = '0;
        o_cmd.kind = sswq_pkg::KIND_ACCEPTED;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op_tick) begin
                    o_cmd.tick_inc = 1'b1;
                    n_nwoke        = '0;
                    n_state        = S_WAKE;
                end else if (i_status.dur_bad) begin
                    n_report = sswq_pkg::KIND_IGNORED;
                    n_state  = S_REPORT;
                end else if (i_status.full) begin
                    n_report = sswq_pkg::KIND_FULL;
                    n_state  = S_REPORT;
                end else begin
                    o_cmd.compare = 1'b1;
                    n_state       = S_INSERT;
                end
            end
            S_INSERT: begin
                if (i_status.out_free) begin
                    o_cmd.insert = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.kind   = sswq_pkg::KIND_ACCEPTED;
                    o_cmd.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = r_report;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WAKE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.head_due) begin
                        o_cmd.pop  = 1'b1;
                        o_cmd.kind = sswq_pkg::KIND_WOKEN;
                        o_cmd.last = !i_status.second_due ||
                                     (r_nwoke == sswq_pkg::WOKE_W'(sswq_pkg::MAX_RESULTS - 1));
                        n_nwoke    = r_nwoke + 1'b1;
                    end else begin
                        // Only reached on the first pass: nothing was due.
                        o_cmd.kind = sswq_pkg::KIND_NONE;
                        o_cmd.last = 1'b1;
                    end
                    if (o_cmd.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_nwoke  <= '0;
            r_report <= sswq_pkg::KIND_ACCEPTED;
        end else begin
            r_state  <= n_state;
            r_nwoke  <= n_nwoke;
            r_report <= n_report;
        end
    end

endmodule

// ===== src/sorted_sleep_wake_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted sleep/wake queue
// Timer wakeup queue: sorted insert of sleeping threads, wake on tick.
// ----------------------------------------------------------------------------
// The block takes one input beat at a time. A sleep request (tuser 0) with a
// positive duration is stored by wake tick, ties going to the higher priority
// and then to the earlier arrival; it answers with one result beat of kind
// accepted, ignored (non-positive duration) or full. A tick (tuser 1) advances
// the 63-bit counter and answers with one woken beat per due thread, at most
// 16, the last one marked with tlast, or a single "nothing woken" beat.
// Timing: every input beat is accepted in the idle state and then decoded in
// the decode state, where a sleep request compares against every slot at
// once and a tick advances the counter. The insert, report or wake state
// then shift-inserts the new entry, reports an ignored or refused request,
// or pops the first woken thread. A tick then pops each further woken thread
// in turn in the wake state, since the store shifts by one slot per pop.
// While the output register still holds a beat that is not taken, the next
// result waits. The next input beat is taken the cycle after the last result
// enters the output register, while that result may still wait to be taken.
// Entries are never cleared, so no initialization pass follows reset.
// ----------------------------------------------------------------------------
module sorted_sleep_wake_queue #(
    parameter int SLOTS = sswq_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [7:0] thread_id, [13:8] thread_priority, [45:14] sleep_duration,
    // [51:46] running_priority, [55:52] zero
    input  logic [sswq_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] operation
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] woken_thread, [8] yield_request, [71:9] tick_now
    output logic [sswq_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [2:0] kind
    output logic [2:0]                          m_axis_tuser,
    output logic                                m_axis_tlast
);

    sswq_pkg::t_cmd              cmd;
    sswq_pkg::t_status           status;
    logic [sswq_pkg::THR_W-1:0]  woken;
    logic                        yield_req;
    logic [sswq_pkg::TICK_W-1:0] tick_now;

    // Controller: owns the input handshake and the sequence of datapath steps.
    sswq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: counter, sorted store and the output register that parts
    // the result side from the input side.
    sswq_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_op       (s_axis_tuser),
        .i_thr      (s_axis_tdata[7:0]),
        .i_pri      (s_axis_tdata[13:8]),
        .i_dur      (s_axis_tdata[45:14]),
        .i_run      (s_axis_tdata[51:46]),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_kind     (m_axis_tuser),
        .o_woken    (woken),
        .o_yield    (yield_req),
        .o_tick     (tick_now),
        .o_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {tick_now, yield_req, woken};

endmodule

// ===== dv/tb_sorted_sleep_wake_queue.sv =====
// ----------------------------------------------------------------------------
// Testbench for the sorted sleep/wake queue
// Drives sleep requests and timer ticks, predicts every result beat in a
// scoreboard and compares the output stream against it field by field.
// ----------------------------------------------------------------------------
module tb_sorted_sleep_wake_queue;

    timeunit 1ns;
    timeprecision 1ps;

    import sswq_pkg::*;

    localparam int          STORE_SLOTS  = SLOTS_DEF;
    localparam int          CLK_HALF     = 6;      // 12 ns period
    localparam int          RESET_CYCLES = 5;
    localparam int          ITEM_TARGET  = 215;    // random items other than ignored sleeps
    localparam int          HOLD_CYCLES  = 300;    // one long receiver hold-off
    localparam int          HOLD_AFTER   = 80;     // output beats before the hold-off
    localparam int          DRAIN_CYCLES = 40;     // settle time after the last result
    localparam int          STALL_LIMIT  = 3000;   // cycles without any beat moving
    localparam int          PRINT_CAP    = 30;
    localparam logic        OP_SLEEP     = 1'b0;
    localparam logic        OP_TICK      = 1'b1;

    // One expected result beat.
    typedef struct packed {
        t_kind             kind;
        logic [THR_W-1:0]  thread;
        logic              yield;
        logic [TICK_W-1:0] tick;
        logic              last;
    } wake_result_t;

    // Scoreboard: a private copy of the timer queue that turns each accepted
    // input beat into the result beats the block must produce for it.
    class wake_scoreboard;
        logic [TICK_W-1:0] tick_count;
        logic [WAKE_W-1:0] wake_at [STORE_SLOTS];
        logic [THR_W-1:0]  owner   [STORE_SLOTS];
        logic [PRI_W-1:0]  prio    [STORE_SLOTS];
        int                held;
        wake_result_t      expected_q [$];
        int unsigned       errors;
        int unsigned       beats_seen;

        function new();
            tick_count = '0;
            held       = 0;
            errors     = 0;
            beats_seen = 0;
        endfunction

        function void expect_beat(t_kind kind, logic [THR_W-1:0] thr, logic yield,
                                  logic last);
            wake_result_t r;
            r.kind   = kind;
            r.thread = thr;
            r.yield  = yield;
            r.tick   = tick_count;
            r.last   = last;
            expected_q.push_back(r);
        endfunction

        function void note_item(logic op, logic [THR_W-1:0] thr, logic [PRI_W-1:0] pri,
                                logic [DUR_W-1:0] dur, logic [PRI_W-1:0] run);
            logic [WAKE_W-1:0] wake;
            logic              earlier;
            logic [THR_W-1:0]  woken;
            logic              yield;
            wake_result_t      tail;
            int                pos;
            int                i;
            int                n;
            if (op == OP_SLEEP) begin
                if (dur == '0 || dur[DUR_W-1]) begin
                    expect_beat(KIND_IGNORED, '0, 1'b0, 1'b1);
                end else if (held >= STORE_SLOTS) begin
                    expect_beat(KIND_FULL, '0, 1'b0, 1'b1);
                end else begin
                    wake = {1'b0, tick_count} + {{(WAKE_W-DUR_W){1'b0}}, dur};
                    // First slot that the new entry goes ahead of: a later wake
                    // tick, or the same wake tick at a lower priority.
                    pos = held;
                    for (i = 0; i < held; i++) begin
                        if (wake_at[i] == wake) earlier = pri > prio[i];
                        else                    earlier = wake < wake_at[i];
                        if (earlier && pos == held) pos = i;
                    end
                    for (i = held; i > pos; i--) begin
                        wake_at[i] = wake_at[i-1];
                        owner[i]   = owner[i-1];
                        prio[i]    = prio[i-1];
                    end
                    wake_at[pos] = wake;
                    owner[pos]   = thr;
                    prio[pos]    = pri;
                    held++;
                    expect_beat(KIND_ACCEPTED, '0, 1'b0, 1'b1);
                end
            end else begin
                tick_count = tick_count + 1'b1;
                n = 0;
                while (held > 0 && n < MAX_RESULTS && wake_at[0] <= {1'b0, tick_count}) begin
                    woken = owner[0];
                    yield = prio[0] > run;
                    for (i = 1; i < held; i++) begin
                        wake_at[i-1] = wake_at[i];
                        owner[i-1]   = owner[i];
                        prio[i-1]    = prio[i];
                    end
                    held--;
                    expect_beat(KIND_WOKEN, woken, yield, 1'b0);
                    n++;
                end
                if (n == 0) begin
                    expect_beat(KIND_NONE, '0, 1'b0, 1'b1);
                end else begin
                    tail = expected_q.pop_back();
                    tail.last = 1'b1;
                    expected_q.push_back(tail);
                end
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_beat(logic [2:0] kind, logic [OUT_DATA_W-1:0] data, logic last);
            wake_result_t r;
            beats_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing pending, kind %0d", kind));
                return;
            end
            r = expected_q.pop_front();
            if (kind !== r.kind)
                report_mismatch($sformatf("kind %0d, wanted %0d", kind, r.kind));
            if (data[7:0] !== r.thread)
                report_mismatch($sformatf("woken thread %0d, wanted %0d", data[7:0], r.thread));
            if (data[8] !== r.yield)
                report_mismatch($sformatf("yield %b, wanted %b", data[8], r.yield));
            if (data[71:9] !== r.tick)
                report_mismatch($sformatf("tick %0d, wanted %0d", data[71:9], r.tick));
            if (last !== r.last)
                report_mismatch($sformatf("tlast %b, wanted %b", last, r.last));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every input of the block starts at a known value.
    // ------------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [7:0] thread_id, [13:8] thread_priority, [45:14] sleep_duration,
    // [51:46] running_priority, [55:52] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // [0] operation
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [7:0] woken_thread, [8] yield_request, [71:9] tick_now
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [2:0] kind
    logic [2:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    wake_scoreboard sb = new();

    sorted_sleep_wake_queue #(
        .SLOTS (STORE_SLOTS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Idle length for either side: mostly none, often a few cycles, now and
    // then a long stretch.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offers one input beat and holds it until the block takes it. The
    // scoreboard learns of the beat at the edge where it is accepted. Unless
    // the sender is in a calm stretch, tvalid may then drop for a random gap.
    // A following beat with no gap keeps tvalid high, so it never drops and
    // rises within one time step.
    task automatic send_item(input logic op, input logic [THR_W-1:0] thr,
                             input logic [PRI_W-1:0] pri, input logic [DUR_W-1:0] dur,
                             input logic [PRI_W-1:0] run, input bit calm);
        int gap;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, run, dur, pri, thr};
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(op, thr, pri, dur, run);
        gap = calm ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result monitor. Outputs are read in the active region right after the
    // rising edge, so they hold the values the edge itself sampled.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // ------------------------------------------------------------------------
    // Receiver. tready alternates between open stretches and gaps of random
    // length. Once enough beats have come out it closes for a long stretch
    // while the sender keeps offering, so the output register stays full and
    // the block has to hold off its input.
    // ------------------------------------------------------------------------
    initial begin : receiver
        bit held_off;
        int open_len;
        int gap;
        held_off = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && sb.beats_seen >= HOLD_AFTER) begin
                held_off = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            // Now and then a long open stretch with no stalls at all.
            open_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 20);
            m_axis_tready <= 1'b1;
            repeat (open_len) @(posedge i_clk);
            gap = pick_gap();
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no beat moves on either side for too long.
    // The long hold-off and the slowest item stay well below the limit.
    // ------------------------------------------------------------------------
    int stall_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int               k;
        int               counted;
        int               phase_len;
        int               sleep_pct;
        int               r;
        bit               calm;
        logic             op;
        logic [THR_W-1:0] thr;
        logic [PRI_W-1:0] pri;
        logic [DUR_W-1:0] dur;
        logic [PRI_W-1:0] run;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Durations of zero, minus one and the most negative value are all
        // ignored; the first two put the thread fields at their extremes.
        send_item(OP_SLEEP, 8'h00, 6'd0,  32'h0000_0000, 6'd63, 1'b0);
        send_item(OP_SLEEP, 8'hFF, 6'd63, 32'hFFFF_FFFF, 6'd0,  1'b0);
        send_item(OP_SLEEP, 8'h5A, 6'd21, 32'h8000_0000, 6'd42, 1'b0);

        // A tick on an empty store wakes nobody; its thread fields are noise.
        send_item(OP_TICK, 8'hFF, 6'd63, 32'h7FFF_FFFF, 6'd63, 1'b0);

        // Fill every slot with the same wake tick. Priorities cycle through
        // 0, 21, 42 and 63, so ties are broken by priority and, within one
        // priority, by arrival order.
        for (k = 0; k < STORE_SLOTS; k++)
            send_item(OP_SLEEP, 8'(k * 17), 6'((k % 4) * 21), 32'd1, 6'(k * 4), 1'b0);

        // The store is full now, so this request is refused.
        send_item(OP_SLEEP, 8'hC3, 6'd63, 32'd1, 6'd0, 1'b0);

        // One tick wakes all sixteen. Running priority 21 makes the threads at
        // priority 21 the equal case that must not ask for a yield.
        send_item(OP_TICK, 8'h00, 6'd0, 32'd0, 6'd21, 1'b0);

        // A later arrival with an earlier wake tick goes to the head.
        send_item(OP_SLEEP, 8'h11, 6'd5, 32'd2, 6'd0, 1'b0);
        send_item(OP_SLEEP, 8'h22, 6'd5, 32'd1, 6'd0, 1'b0);
        send_item(OP_TICK,  8'h00, 6'd0, 32'd0, 6'd4, 1'b0);
        send_item(OP_TICK,  8'h00, 6'd0, 32'd0, 6'd5, 1'b0);

        // The longest legal duration parks an entry for the rest of the run.
        send_item(OP_SLEEP, 8'hAA, 6'd63, 32'h7FFF_FFFF, 6'd0, 1'b0);

        // Random part, in phases with their own mix of sleeps and ticks and
        // sometimes no sender gaps at all. Durations are mostly short so that
        // wake ticks collide and threads wake within a few ticks; a few are
        // huge and stay parked, a few are non-positive.
        counted = 0;
        while (counted < ITEM_TARGET) begin
            r         = $urandom_range(0, 2);
            sleep_pct = (r == 0) ? 30 : (r == 1) ? 55 : 80;
            calm      = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(16, 24);
            for (k = 0; k < phase_len; k++) begin
                op  = ($urandom_range(0, 99) < sleep_pct) ? OP_SLEEP : OP_TICK;
                thr = THR_W'($urandom_range(0, 255));
                pri = ($urandom_range(0, 1) == 0) ? PRI_W'($urandom_range(0, 3) * 21)
                                                  : PRI_W'($urandom_range(0, 63));
                run = PRI_W'($urandom_range(0, 63));
                r   = $urandom_range(0, 99);
                if (r < 2)       dur = '0;
                else if (r < 8)  dur = $urandom | 32'h8000_0000;
                else if (r < 10) dur = $urandom & 32'h7FFF_FFFF;
                else             dur = DUR_W'($urandom_range(1, 6));
                send_item(op, thr, pri, dur, run, calm);
                if (!(op == OP_SLEEP && (dur == '0 || dur[DUR_W-1])))
                    counted++;
            end
        end
        s_axis_tvalid <= 1'b0;

        // Let every pending result come out, then give the block time to
        // show any stray beat before deciding.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
